// ===== hw/rtl/bma_pkg.sv =====
// ----------------------------------------------------------------------------
// bma_pkg
// Shared types and constants of the boxcar moving-average core.
// ----------------------------------------------------------------------------
package bma_pkg;

  localparam int unsigned SampleW = 12;
  localparam int unsigned CfgW    = 5;

  localparam logic [CfgW-1:0] WindowReset = 5'd16;

  typedef struct packed {
    logic               valid;
    logic [SampleW-1:0] sample;
  } item_t;

  typedef enum logic [3:0] {
    BackIdle   = 4'b0001,
    BackUpdate = 4'b0010,
    BackDivide = 4'b0100,
    BackOutput = 4'b1000
  } back_state_e;

endpackage

// ===== hw/rtl/bma_front.sv =====
// ----------------------------------------------------------------------------
// bma_front
// Input stage: takes one sample request per cycle while not full and hands it to the queue.
// ----------------------------------------------------------------------------
module bma_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [bma_pkg::SampleW-1:0]    sample_value_i,
  output bma_pkg::item_t                 item_o,
  input  logic                           ready_i
);

  bma_pkg::item_t item_q, item_d;
  logic           accept;

  assign full   = item_q.valid && !ready_i;
  assign accept = push && !full;
  assign item_o = item_q;

  always_comb begin
    item_d = item_q;
    if (accept) begin
      item_d.valid  = 1'b1;
      item_d.sample = sample_value_i;
    end else if (ready_i) begin
      item_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
    end else begin
      item_q <= item_d;
    end
  end

endmodule

// ===== hw/rtl/bma_queue.sv =====
// ----------------------------------------------------------------------------
// bma_queue
// Two-entry queue that decouples the input stage from the filter datapath.
// ----------------------------------------------------------------------------
module bma_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bma_pkg::item_t item_i,
  output logic           ready_o,
  output bma_pkg::item_t item_o,
  input  logic           ready_i
);

  logic [bma_pkg::SampleW-1:0] slot_q [2];
  logic                        wr_ptr_q, rd_ptr_q;
  logic [1:0]                  count_q;
  logic                        wr_en, rd_en;

  assign ready_o     = (count_q != 2'd2);
  assign wr_en       = item_i.valid && ready_o;
  assign item_o.valid  = (count_q != 2'd0);
  assign item_o.sample = slot_q[rd_ptr_q];
  assign rd_en       = item_o.valid && ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (rd_en) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({wr_en, rd_en})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_q[wr_ptr_q] <= item_i.sample;
    end
  end

endmodule

// ===== hw/rtl/bma_back.sv =====
// ----------------------------------------------------------------------------
// bma_back
// Filter datapath: sample ring, running sum, bit-serial divider and the
// result register.
// ----------------------------------------------------------------------------
module bma_back #(
  parameter int unsigned MAX_WINDOW = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  clear_i,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]       eff_len_i,
  input  bma_pkg::item_t                        item_i,
  output logic                                  ready_o,
  output logic                                  empty,
  input  logic                                  pop,
  output logic [bma_pkg::SampleW-1:0]           average_value_o,
  output logic [((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1)-1:0] stat_pos_o,
  output logic [$clog2(MAX_WINDOW*4095+1)-1:0]  stat_sum_o
);

  localparam int unsigned LenW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned PosW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned SumW = $clog2(MAX_WINDOW * 4095 + 1);
  localparam int unsigned CntW = $clog2(SumW);

  bma_pkg::back_state_e state_q, state_d;

  logic [bma_pkg::SampleW-1:0] ring_mem [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]       ring_vld_q;
  logic [bma_pkg::SampleW-1:0] rd_data_q, sample_q, old_sample;
  logic                        rd_vld_q;
  logic [PosW-1:0]             pos_q, pos_cur, pos_next;
  logic [SumW-1:0]             sum_q, sum_d;
  logic [SumW-1:0]             dq_q;
  logic [LenW-1:0]             rem_q;
  logic [LenW:0]               trial, trial_sub;
  logic                        trial_ge;
  logic [CntW-1:0]             cnt_q;
  logic                        out_vld_q;
  logic [bma_pkg::SampleW-1:0] out_q;
  logic                        take, out_load;

  assign pos_cur  = (9'(pos_q) >= 9'(eff_len_i)) ? '0 : pos_q;
  assign pos_next = (9'(pos_cur) + 9'd1 >= 9'(eff_len_i)) ? '0 : PosW'(pos_cur + 1'b1);

  assign old_sample = rd_vld_q ? rd_data_q : '0;
  assign sum_d      = sum_q + SumW'(sample_q) - SumW'(old_sample);

  assign trial     = {rem_q, dq_q[SumW-1]};
  assign trial_sub = trial - {1'b0, eff_len_i};
  assign trial_ge  = (trial >= {1'b0, eff_len_i});

  assign ready_o  = (state_q == bma_pkg::BackIdle);
  assign take     = ready_o && item_i.valid;
  assign out_load = (state_q == bma_pkg::BackOutput) && (!out_vld_q || pop);

  assign empty           = !out_vld_q;
  assign average_value_o = out_q;
  assign stat_pos_o      = pos_q;
  assign stat_sum_o      = sum_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      bma_pkg::BackIdle: begin
        if (item_i.valid) begin
          state_d = bma_pkg::BackUpdate;
        end
      end
      bma_pkg::BackUpdate: begin
        state_d = bma_pkg::BackDivide;
      end
      bma_pkg::BackDivide: begin
        if (cnt_q == CntW'(SumW - 1)) begin
          state_d = bma_pkg::BackOutput;
        end
      end
      bma_pkg::BackOutput: begin
        if (out_load) begin
          state_d = bma_pkg::BackIdle;
        end
      end
      default: begin
        state_d = bma_pkg::BackIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= bma_pkg::BackIdle;
      ring_vld_q <= '0;
      pos_q      <= '0;
      sum_q      <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clear_i) begin
        ring_vld_q <= '0;
        pos_q      <= '0;
        sum_q      <= '0;
      end else if (state_q == bma_pkg::BackUpdate) begin
        ring_vld_q[pos_cur] <= 1'b1;
        pos_q               <= pos_next;
        sum_q               <= sum_d;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (pop && out_vld_q) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      sample_q  <= item_i.sample;
      rd_data_q <= ring_mem[pos_cur];
      rd_vld_q  <= ring_vld_q[pos_cur];
    end
    if (state_q == bma_pkg::BackUpdate) begin
      ring_mem[pos_cur] <= sample_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == bma_pkg::BackUpdate) begin
      dq_q  <= sum_d;
      rem_q <= '0;
      cnt_q <= '0;
    end else if (state_q == bma_pkg::BackDivide) begin
      dq_q  <= {dq_q[SumW-2:0], trial_ge};
      rem_q <= trial_ge ? trial_sub[LenW-1:0] : trial[LenW-1:0];
      cnt_q <= cnt_q + 1'b1;
    end
    if (out_load) begin
      out_q <= dq_q[bma_pkg::SampleW-1:0];
    end
  end

endmodule

// ===== hw/rtl/boxcar_moving_average_core.sv =====
// ----------------------------------------------------------------------------
// boxcar_moving_average_core
// Boxcar moving average of 12-bit converter samples over a programmable
// window.
// ----------------------------------------------------------------------------
// Each sample request yields one result, the truncated mean of the last
// window-length samples, where samples not yet seen count as zero. The
// window register takes 1 to MAX_WINDOW; zero reads as one and larger values
// as MAX_WINDOW. A write to it clears the sample history and the running sum.
// Each sample passes through the update state, the bit-serial divider
// and the output state before the back end takes the next one. A two-entry
// queue and an input register let the source push ahead while a result
// waits to be popped.
module boxcar_moving_average_core #(
  parameter int unsigned MAX_WINDOW = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bma_pkg::CfgW-1:0]          cfg_wdata_i,
  input  logic                              push,
  output logic                              full,
  input  logic [bma_pkg::SampleW-1:0]       sample_value_i,
  output logic                              empty,
  input  logic                              pop,
  output logic [bma_pkg::SampleW-1:0]       average_value_o
);

  localparam int unsigned LenW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned PosW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned SumW = $clog2(MAX_WINDOW * 4095 + 1);
  localparam logic [8:0]  MaxWin = 9'(MAX_WINDOW);

  logic [bma_pkg::CfgW-1:0] window_q;
  logic [8:0]               win_ext, eff_ext;
  logic [LenW-1:0]          eff_len;
  bma_pkg::item_t           front_item, queue_item;
  logic                     queue_ready, back_ready;
  logic [PosW-1:0]          stat_pos;
  logic [SumW-1:0]          stat_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= bma_pkg::WindowReset;
    end else if (cfg_we_i) begin
      window_q <= cfg_wdata_i;
    end
  end

  assign win_ext = 9'(window_q);
  assign eff_ext = (window_q == '0) ? 9'd1 : ((win_ext > MaxWin) ? MaxWin : win_ext);
  assign eff_len = eff_ext[LenW-1:0];

  bma_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .sample_value_i (sample_value_i),
    .item_o         (front_item),
    .ready_i        (queue_ready)
  );

  bma_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (front_item),
    .ready_o (queue_ready),
    .item_o  (queue_item),
    .ready_i (back_ready)
  );

  bma_back #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .clear_i         (cfg_we_i),
    .eff_len_i       (eff_len),
    .item_i          (queue_item),
    .ready_o         (back_ready),
    .empty           (empty),
    .pop             (pop),
    .average_value_o (average_value_o),
    .stat_pos_o      (stat_pos),
    .stat_sum_o      (stat_sum)
  );

  // The write position always stays inside the effective window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    9'(stat_pos) < 9'(eff_len))
    else $error("write position outside the window");

  // The running sum never exceeds a full window of maximum samples.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(stat_sum) <= 32'(eff_len) * 32'd4095)
    else $error("running sum exceeds the window bound");

  // A window write restarts the history.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (stat_sum == '0) && (stat_pos == '0))
    else $error("window write did not clear the history");

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the boxcar moving-average core. Samples are
// pushed in random bursts while results are popped on an independent stall
// pattern. Every result is compared with the output of a local average
// predictor that tracks the window register, the sample history and the sum.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxWindow     = 16;
  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned DrainCycles   = 40;
  localparam logic [bma_pkg::SampleW-1:0] SampleMax = '1;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we = 1'b0;
  logic [bma_pkg::CfgW-1:0]    cfg_wdata = '0;
  logic                        push = 1'b0;
  logic                        full;
  logic [bma_pkg::SampleW-1:0] sample_value = '0;
  logic                        empty;
  logic                        pop = 1'b0;
  logic [bma_pkg::SampleW-1:0] average_value;

  logic [bma_pkg::SampleW-1:0] history [MaxWindow];
  int unsigned                 slot;
  logic [15:0]                 window_sum;
  logic [bma_pkg::CfgW-1:0]    window_reg;

  logic [bma_pkg::SampleW-1:0] expected_averages [$];
  int unsigned        mismatch_count = 0;
  int unsigned        sample_count = 0;
  int unsigned        result_count = 0;
  int unsigned        windows_written = 0;
  int unsigned        burst_left = 0;
  int unsigned        idle_cycles = 0;
  bit                 steady_phase = 1'b0;

  boxcar_moving_average_core #(
    .MAX_WINDOW(MaxWindow)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .push           (push),
    .full           (full),
    .sample_value_i (sample_value),
    .empty          (empty),
    .pop            (pop),
    .average_value_o(average_value)
  );

  always #10 clk_i = ~clk_i;

  function automatic int unsigned window_span(logic [bma_pkg::CfgW-1:0] w);
    if (w == 0) return 1;
    if (w > MaxWindow) return MaxWindow;
    return w;
  endfunction

  function automatic void clear_history();
    foreach (history[i]) history[i] = '0;
    slot = 0;
    window_sum = '0;
  endfunction

  function automatic logic [bma_pkg::SampleW-1:0] average_after_sample(
      logic [bma_pkg::SampleW-1:0] s);
    int unsigned n;
    n = window_span(window_reg);
    if (slot >= n) slot = 0;
    window_sum = window_sum + s - history[slot];
    history[slot] = s;
    slot++;
    if (slot >= n) slot = 0;
    return bma_pkg::SampleW'(window_sum / n);
  endfunction

  function automatic logic [bma_pkg::SampleW-1:0] random_sample(
      logic [bma_pkg::SampleW-1:0] last);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return SampleMax;
      2: return bma_pkg::SampleW'($urandom_range(4000, 4095));
      3, 4: return last;
      default: return bma_pkg::SampleW'($urandom);
    endcase
  endfunction

  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      if (steady_phase || $urandom_range(0, 4) == 0) gap = 0;
      else gap = $urandom_range(1, 30);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 10);
    end
  endtask

  task automatic send_sample(input logic [bma_pkg::SampleW-1:0] value);
    push <= 1'b1;
    sample_value <= value;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    expected_averages.push_back(average_after_sample(value));
    sample_count++;
    pace_sender();
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk_i);
    while (expected_averages.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [bma_pkg::CfgW-1:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    window_reg = value;
    clear_history();
    windows_written++;
  endtask

  task automatic test_reset_window();
    send_sample('0);
    send_sample(SampleMax);
    send_sample(SampleMax);
    send_sample(12'hAAA);
    send_sample(12'h555);
    send_sample(12'h001);
    send_sample(12'h800);
    send_sample(SampleMax);
  endtask

  task automatic test_window_extremes();
    write_window(5'd1);
    send_sample(SampleMax);
    send_sample('0);
    send_sample(12'h7FF);
    write_window(5'd0);
    send_sample(12'h123);
    send_sample(SampleMax);
    send_sample(12'h001);
    write_window(5'd31);
    send_sample(SampleMax);
    send_sample(SampleMax);
    send_sample(12'hFFE);
    send_sample('0);
    write_window(5'd17);
    send_sample(SampleMax);
    send_sample(12'h456);
  endtask

  task automatic test_random_windows();
    logic [bma_pkg::SampleW-1:0] last;
    logic [bma_pkg::CfgW-1:0]    w;
    last = '0;
    for (int phase = 0; phase < 10; phase++) begin
      if (phase == 0) w = bma_pkg::WindowReset;
      else if (phase == 1) w = 5'd3;
      else if ($urandom_range(0, 3) == 0) w = bma_pkg::CfgW'($urandom_range(0, 31));
      else w = bma_pkg::CfgW'($urandom_range(1, 16));
      write_window(w);
      steady_phase = (phase % 3 == 2);
      for (int k = 0; k < 50; k++) begin
        last = random_sample(last);
        send_sample(last);
      end
    end
    steady_phase = 1'b0;
  endtask

  initial begin : drain_side
    int unsigned run_len;
    int unsigned stall_len;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      pop <= 1'b1;
      run_len = $urandom_range(1, 12);
      repeat (run_len) @(posedge clk_i);
      if (steady_phase || $urandom_range(0, 3) == 0) stall_len = 0;
      else stall_len = $urandom_range(1, 40);
      if (stall_len != 0) begin
        pop <= 1'b0;
        repeat (stall_len) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      result_count++;
      if (expected_averages.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $time,
                 average_value);
        mismatch_count++;
      end else begin
        if (average_value !== expected_averages[0]) begin
          $display("%0t: average mismatch, expected %0d, actual %0d", $time,
                   expected_averages[0], average_value);
          mismatch_count++;
        end
        void'(expected_averages.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: watchdog expired with %0d results outstanding", $time,
                 expected_averages.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    window_reg = bma_pkg::WindowReset;
    clear_history();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_window();
    test_window_extremes();
    test_random_windows();
    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_averages.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time,
               expected_averages.size());
      mismatch_count++;
    end
    $display("Pushed %0d samples and checked %0d averages.", sample_count, result_count);
    $display("Window register written %0d times, zero and saturating values included.",
             windows_written);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
